/* src/vmmio_pkg.sv */
// Shared types and constants of the virtio MMIO register block.
// Holds the register map, command and size codes, and controller/datapath links.
// No dependencies.
package vmmio_pkg;

    localparam int QUEUE_COUNT_DEF    = 8;
    localparam int QUEUE_SIZE_MAX_DEF = 16;
    localparam int CONFIG_BYTES_DEF   = 256;

    localparam logic [31:0] MAGIC_WORD    = 32'h7472_6976;
    localparam logic [31:0] VERSION_WORD  = 32'd2;
    localparam logic [11:0] CFG_BASE      = 12'h100;

    localparam logic [11:0] OFF_MAGIC     = 12'h000;
    localparam logic [11:0] OFF_VERSION   = 12'h004;
    localparam logic [11:0] OFF_DEV_ID    = 12'h008;
    localparam logic [11:0] OFF_VENDOR_ID = 12'h00c;
    localparam logic [11:0] OFF_DEV_FEAT  = 12'h010;
    localparam logic [11:0] OFF_FEAT_SEL  = 12'h014;
    localparam logic [11:0] OFF_QUEUE_SEL = 12'h030;
    localparam logic [11:0] OFF_QUEUE_MAX = 12'h034;
    localparam logic [11:0] OFF_QUEUE_NUM = 12'h038;
    localparam logic [11:0] OFF_QUEUE_RDY = 12'h044;
    localparam logic [11:0] OFF_NOTIFY    = 12'h050;
    localparam logic [11:0] OFF_INT_STAT  = 12'h060;
    localparam logic [11:0] OFF_INT_ACK   = 12'h064;
    localparam logic [11:0] OFF_STATUS    = 12'h070;
    localparam logic [11:0] OFF_DESC_LO   = 12'h080;
    localparam logic [11:0] OFF_DESC_HI   = 12'h084;
    localparam logic [11:0] OFF_AVAIL_LO  = 12'h090;
    localparam logic [11:0] OFF_AVAIL_HI  = 12'h094;
    localparam logic [11:0] OFF_USED_LO   = 12'h0a0;
    localparam logic [11:0] OFF_USED_HI   = 12'h0a4;

    localparam logic [1:0] CMD_READ      = 2'd0;
    localparam logic [1:0] CMD_WRITE     = 2'd1;
    localparam logic [1:0] CMD_USED_EVT  = 2'd2;
    localparam logic [1:0] CMD_CFG_EVT   = 2'd3;

    localparam logic [1:0] SZ_BYTE       = 2'd0;
    localparam logic [1:0] SZ_HALF       = 2'd1;
    localparam logic [1:0] SZ_WORD       = 2'd2;
    localparam logic [1:0] SZ_RSVD       = 2'd3;

    localparam logic [1:0] CREG_DEVICE_KIND  = 2'd0;
    localparam logic [1:0] CREG_VENDOR_CODE  = 2'd1;
    localparam logic [1:0] CREG_FEATURE_BITS = 2'd2;
    localparam logic [1:0] CREG_CONFIG_SIZE  = 2'd3;

    localparam logic [31:0] DEVICE_KIND_RST  = 32'd2;
    localparam logic [31:0] VENDOR_CODE_RST  = 32'h0000_ffff;
    localparam logic [31:0] FEATURE_BITS_RST = 32'd0;
    localparam logic [8:0]  CONFIG_SIZE_RST  = 9'd8;

    typedef struct packed {
        logic       accept;
        logic       exec;
        logic       mem_rd;
        logic       capture;
        logic       mem_wr;
        logic       load_out;
        logic [1:0] byte_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic cfg_rd;
        logic cfg_wr;
        logic byte_last;
        logic out_busy;
    } dp_sts_t;

endpackage

/* src/vmmio_ctrl.sv */
// Sequencer of the virtio MMIO register block: decode, config byte loop, result hand-off.
// Depends on vmmio_pkg for the command and status structs.
module vmmio_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  vmmio_pkg::dp_sts_t sts,
    output vmmio_pkg::dp_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD_ADDR,
        S_RD_DATA,
        S_WR,
        S_DONE
    } state_t;

    state_t     state_reg;
    logic       s_ready_reg;
    logic [1:0] byte_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            s_ready_reg  <= 1'b1;
            byte_idx_reg <= 2'd0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready_reg) begin
                        state_reg   <= S_DECODE;
                        s_ready_reg <= 1'b0;
                    end
                end
                S_DECODE: begin
                    byte_idx_reg <= 2'd0;
                    if (sts.cfg_rd) begin
                        state_reg <= S_RD_ADDR;
                    end else if (sts.cfg_wr) begin
                        state_reg <= S_WR;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_RD_ADDR: begin
                    state_reg <= S_RD_DATA;
                end
                S_RD_DATA: begin
                    if (sts.byte_last) begin
                        state_reg <= S_DONE;
                    end else begin
                        byte_idx_reg <= byte_idx_reg + 2'd1;
                        state_reg    <= S_RD_ADDR;
                    end
                end
                S_WR: begin
                    if (sts.byte_last) begin
                        state_reg <= S_DONE;
                    end else begin
                        byte_idx_reg <= byte_idx_reg + 2'd1;
                    end
                end
                S_DONE: begin
                    if (!sts.out_busy) begin
                        state_reg   <= S_IDLE;
                        s_ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg   <= S_IDLE;
                    s_ready_reg <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        cmd          = '0;
        cmd.byte_idx = byte_idx_reg;
        cmd.accept   = (state_reg == S_IDLE) && s_valid && s_ready_reg;
        cmd.exec     = (state_reg == S_DECODE) && !sts.cfg_rd && !sts.cfg_wr;
        cmd.mem_rd   = (state_reg == S_RD_ADDR);
        cmd.capture  = (state_reg == S_RD_DATA);
        cmd.mem_wr   = (state_reg == S_WR);
        cmd.load_out = (state_reg == S_DONE) && !sts.out_busy;
    end

    assign s_ready = s_ready_reg;

`ifndef SYNTHESIS
    a_accept_decodes: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> state_reg == S_DECODE)
        else $error("accepted beat not decoded");
    a_load_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> s_ready)
        else $error("input not reopened after result load");
    a_wr_in_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_wr |-> sts.cfg_wr)
        else $error("config write without in-bounds access");
`endif

endmodule

/* src/vmmio_dp.sv */
// Datapath of the virtio MMIO register block: transport registers, queue file,
// device config byte store and the result register. Depends on vmmio_pkg.
module vmmio_dp #(
    parameter int QUEUE_COUNT    = vmmio_pkg::QUEUE_COUNT_DEF,
    parameter int QUEUE_SIZE_MAX = vmmio_pkg::QUEUE_SIZE_MAX_DEF,
    parameter int CONFIG_BYTES   = vmmio_pkg::CONFIG_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_wr_data,
    input  logic [1:0]         s_cmd,
    input  logic [11:0]        s_bus_offset,
    input  logic [31:0]        s_write_value,
    input  logic [1:0]         s_size_code,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_read_value,
    output logic               m_irq_level,
    output logic               m_notify_seen,
    output logic [2:0]         m_notify_queue,
    output logic               m_config_touched,
    input  vmmio_pkg::dp_cmd_t cmd,
    output vmmio_pkg::dp_sts_t sts
);

    localparam int QW     = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int CFG_AW = $clog2(CONFIG_BYTES);

    logic [31:0] device_kind_reg;
    logic [31:0] vendor_code_reg;
    logic [31:0] feature_bits_reg;
    logic [8:0]  config_size_reg;

    logic [1:0]  cmd_reg;
    logic [11:0] off_reg;
    logic [31:0] val_reg;
    logic [1:0]  sz_reg;

    logic [31:0]   device_status_reg;
    logic [31:0]   feature_select_reg;
    logic [QW-1:0] sel_q_reg;
    logic [1:0]    int_status_reg;
    logic          queue_ready_reg [QUEUE_COUNT];
    logic [31:0]   queue_size_reg  [QUEUE_COUNT];
    logic [63:0]   desc_addr_reg   [QUEUE_COUNT];
    logic [63:0]   avail_addr_reg  [QUEUE_COUNT];
    logic [63:0]   used_addr_reg   [QUEUE_COUNT];

    logic [7:0]              cfg_mem [CONFIG_BYTES];
    logic [CONFIG_BYTES-1:0] cfg_vld_reg;
    logic [7:0]              rdata_reg;
    logic                    rvld_reg;

    logic [31:0] acc_reg;
    logic        nseen_reg;
    logic [2:0]  nq_reg;

    logic        out_valid_reg;
    logic [31:0] out_rd_reg;
    logic        out_irq_reg;
    logic        out_nseen_reg;
    logic [2:0]  out_nq_reg;
    logic        out_touched_reg;

    logic [11:0]       cfg_off;
    logic [2:0]        nbytes;
    logic [8:0]        bound;
    logic [12:0]       acc_end;
    logic              in_bounds;
    logic              is_cfg;
    logic [11:0]       mem_full;
    logic [CFG_AW-1:0] mem_addr;
    logic              reg_access;
    logic              wr_hit;
    logic              soft_rst;
    logic [31:0]       reg_rdata;
    logic [QW-1:0]     q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_kind_reg  <= vmmio_pkg::DEVICE_KIND_RST;
            vendor_code_reg  <= vmmio_pkg::VENDOR_CODE_RST;
            feature_bits_reg <= vmmio_pkg::FEATURE_BITS_RST;
            config_size_reg  <= vmmio_pkg::CONFIG_SIZE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                vmmio_pkg::CREG_DEVICE_KIND:  device_kind_reg  <= cfg_wr_data;
                vmmio_pkg::CREG_VENDOR_CODE:  vendor_code_reg  <= cfg_wr_data;
                vmmio_pkg::CREG_FEATURE_BITS: feature_bits_reg <= cfg_wr_data;
                vmmio_pkg::CREG_CONFIG_SIZE:  config_size_reg  <= cfg_wr_data[8:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cmd_reg <= s_cmd;
            off_reg <= s_bus_offset;
            val_reg <= s_write_value;
            sz_reg  <= s_size_code;
        end
    end

    assign cfg_off   = off_reg - vmmio_pkg::CFG_BASE;
    assign nbytes    = 3'd1 << sz_reg;
    assign bound     = (config_size_reg > 9'(CONFIG_BYTES)) ? 9'(CONFIG_BYTES)
                                                            : config_size_reg;
    assign acc_end   = {1'b0, cfg_off} + 13'(nbytes);
    assign in_bounds = acc_end <= 13'(bound);
    assign is_cfg    = (off_reg >= vmmio_pkg::CFG_BASE) && (sz_reg != vmmio_pkg::SZ_RSVD)
                       && in_bounds;
    assign mem_full  = cfg_off + 12'(cmd.byte_idx);
    assign mem_addr  = mem_full[CFG_AW-1:0];

    assign sts.cfg_rd    = is_cfg && (cmd_reg == vmmio_pkg::CMD_READ);
    assign sts.cfg_wr    = is_cfg && (cmd_reg == vmmio_pkg::CMD_WRITE);
    assign sts.byte_last = (3'(cmd.byte_idx) + 3'd1) == nbytes;
    assign sts.out_busy  = out_valid_reg && !m_ready;

    assign q          = sel_q_reg;
    assign reg_access = (off_reg < vmmio_pkg::CFG_BASE) && (sz_reg == vmmio_pkg::SZ_WORD);
    assign wr_hit     = cmd.exec && reg_access && (cmd_reg == vmmio_pkg::CMD_WRITE);
    assign soft_rst   = wr_hit && (off_reg == vmmio_pkg::OFF_STATUS) && (val_reg == 32'd0);

    always_comb begin
        reg_rdata = 32'd0;
        if (reg_access && (cmd_reg == vmmio_pkg::CMD_READ)) begin
            case (off_reg)
                vmmio_pkg::OFF_MAGIC:     reg_rdata = vmmio_pkg::MAGIC_WORD;
                vmmio_pkg::OFF_VERSION:   reg_rdata = vmmio_pkg::VERSION_WORD;
                vmmio_pkg::OFF_DEV_ID:    reg_rdata = device_kind_reg;
                vmmio_pkg::OFF_VENDOR_ID: reg_rdata = vendor_code_reg;
                vmmio_pkg::OFF_DEV_FEAT: begin
                    if (feature_select_reg == 32'd0) begin
                        reg_rdata = feature_bits_reg;
                    end else if (feature_select_reg == 32'd1) begin
                        reg_rdata = 32'd1;
                    end
                end
                vmmio_pkg::OFF_FEAT_SEL:  reg_rdata = feature_select_reg;
                vmmio_pkg::OFF_QUEUE_SEL: reg_rdata = 32'(sel_q_reg);
                vmmio_pkg::OFF_QUEUE_MAX: reg_rdata = 32'(QUEUE_SIZE_MAX);
                vmmio_pkg::OFF_QUEUE_NUM: reg_rdata = queue_size_reg[q];
                vmmio_pkg::OFF_QUEUE_RDY: reg_rdata = 32'(queue_ready_reg[q]);
                vmmio_pkg::OFF_INT_STAT:  reg_rdata = 32'(int_status_reg);
                vmmio_pkg::OFF_STATUS:    reg_rdata = device_status_reg;
                vmmio_pkg::OFF_DESC_LO:   reg_rdata = desc_addr_reg[q][31:0];
                vmmio_pkg::OFF_DESC_HI:   reg_rdata = desc_addr_reg[q][63:32];
                vmmio_pkg::OFF_AVAIL_LO:  reg_rdata = avail_addr_reg[q][31:0];
                vmmio_pkg::OFF_AVAIL_HI:  reg_rdata = avail_addr_reg[q][63:32];
                vmmio_pkg::OFF_USED_LO:   reg_rdata = used_addr_reg[q][31:0];
                vmmio_pkg::OFF_USED_HI:   reg_rdata = used_addr_reg[q][63:32];
                default:                  reg_rdata = 32'd0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || soft_rst) begin
            device_status_reg  <= 32'd0;
            feature_select_reg <= 32'd0;
            sel_q_reg          <= '0;
            int_status_reg     <= 2'd0;
            for (int i = 0; i < QUEUE_COUNT; i++) begin
                queue_ready_reg[i] <= 1'b0;
                queue_size_reg[i]  <= 32'(QUEUE_SIZE_MAX);
                desc_addr_reg[i]   <= 64'd0;
                avail_addr_reg[i]  <= 64'd0;
                used_addr_reg[i]   <= 64'd0;
            end
        end else if (cmd.exec) begin
            if (cmd_reg == vmmio_pkg::CMD_USED_EVT) begin
                int_status_reg[0] <= 1'b1;
            end else if (cmd_reg == vmmio_pkg::CMD_CFG_EVT) begin
                int_status_reg[1] <= 1'b1;
            end else if (wr_hit) begin
                case (off_reg)
                    vmmio_pkg::OFF_FEAT_SEL: feature_select_reg <= val_reg;
                    vmmio_pkg::OFF_QUEUE_SEL: begin
                        if (val_reg < 32'(QUEUE_COUNT)) begin
                            sel_q_reg <= val_reg[QW-1:0];
                        end
                    end
                    vmmio_pkg::OFF_QUEUE_NUM: begin
                        if ((val_reg != 32'd0) && ((val_reg & (val_reg - 32'd1)) == 32'd0)) begin
                            queue_size_reg[q] <= val_reg;
                        end
                    end
                    vmmio_pkg::OFF_QUEUE_RDY: queue_ready_reg[q] <= val_reg[0];
                    vmmio_pkg::OFF_INT_ACK:   int_status_reg <= int_status_reg & ~val_reg[1:0];
                    vmmio_pkg::OFF_STATUS:    device_status_reg <= val_reg;
                    vmmio_pkg::OFF_DESC_LO:   desc_addr_reg[q][31:0]   <= val_reg;
                    vmmio_pkg::OFF_DESC_HI:   desc_addr_reg[q][63:32]  <= val_reg;
                    vmmio_pkg::OFF_AVAIL_LO:  avail_addr_reg[q][31:0]  <= val_reg;
                    vmmio_pkg::OFF_AVAIL_HI:  avail_addr_reg[q][63:32] <= val_reg;
                    vmmio_pkg::OFF_USED_LO:   used_addr_reg[q][31:0]   <= val_reg;
                    vmmio_pkg::OFF_USED_HI:   used_addr_reg[q][63:32]  <= val_reg;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            cfg_mem[mem_addr] <= val_reg[8*cmd.byte_idx +: 8];
        end
        if (cmd.mem_rd) begin
            rdata_reg <= cfg_mem[mem_addr];
            rvld_reg  <= cfg_vld_reg[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_vld_reg <= '0;
        end else if (cmd.mem_wr) begin
            cfg_vld_reg[mem_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            acc_reg   <= 32'd0;
            nseen_reg <= 1'b0;
            nq_reg    <= 3'd0;
        end else if (cmd.exec) begin
            acc_reg <= reg_rdata;
            if (wr_hit && (off_reg == vmmio_pkg::OFF_NOTIFY)
                && (val_reg < 32'(QUEUE_COUNT))) begin
                nseen_reg <= 1'b1;
                nq_reg    <= val_reg[2:0];
            end
        end else if (cmd.capture) begin
            acc_reg[8*cmd.byte_idx +: 8] <= rvld_reg ? rdata_reg : 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_rd_reg      <= acc_reg;
            out_irq_reg     <= |int_status_reg;
            out_nseen_reg   <= nseen_reg;
            out_nq_reg      <= nq_reg;
            out_touched_reg <= sts.cfg_wr;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_read_value     = out_rd_reg;
    assign m_irq_level      = out_irq_reg;
    assign m_notify_seen    = out_nseen_reg;
    assign m_notify_queue   = out_nq_reg;
    assign m_config_touched = out_touched_reg;

`ifndef SYNTHESIS
    a_sel_q_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(sel_q_reg) < 32'(QUEUE_COUNT))
        else $error("selected queue out of range");
    a_mem_wr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_wr |-> (13'(mem_full) < 13'(bound)))
        else $error("config byte written beyond bound");
    a_load_clears_notify: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_out && !nseen_reg) |=> (m_notify_queue == 3'd0))
        else $error("notify queue set without notify");
`endif

endmodule

/* src/virtio_mmio_register_block_top.sv */
// Virtio MMIO (version 2) register block top level.
// Joins vmmio_ctrl and vmmio_dp; depends on vmmio_pkg.
//
// One bus access or interrupt event is taken per beat and returns exactly one
// result beat. The block works on one beat at a time: a register access, an
// event or a rejected access goes through accept, decode and execute, and load
// into the result register. A device config space read visits the single byte-wide
// config store twice per byte (address, then data) and a config write once, one
// byte per visit; the store is read with a registered port. The result register
// frees the input while a finished beat waits on m_ready. The user writes config
// registers through cfg_wr_en/cfg_index/cfg_wr_data only while idle (unchecked).
module virtio_mmio_register_block_top #(
    parameter int QUEUE_COUNT    = vmmio_pkg::QUEUE_COUNT_DEF,
    parameter int QUEUE_SIZE_MAX = vmmio_pkg::QUEUE_SIZE_MAX_DEF,
    parameter int CONFIG_BYTES   = vmmio_pkg::CONFIG_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [11:0] s_bus_offset,
    input  logic [31:0] s_write_value,
    input  logic [1:0]  s_size_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_value,
    output logic        m_irq_level,
    output logic        m_notify_seen,
    output logic [2:0]  m_notify_queue,
    output logic        m_config_touched
);

    vmmio_pkg::dp_cmd_t dp_cmd;
    vmmio_pkg::dp_sts_t dp_sts;

    vmmio_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (dp_sts),
        .cmd     (dp_cmd)
    );

    vmmio_dp #(
        .QUEUE_COUNT    (QUEUE_COUNT),
        .QUEUE_SIZE_MAX (QUEUE_SIZE_MAX),
        .CONFIG_BYTES   (CONFIG_BYTES)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_cmd            (s_cmd),
        .s_bus_offset     (s_bus_offset),
        .s_write_value    (s_write_value),
        .s_size_code      (s_size_code),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_read_value     (m_read_value),
        .m_irq_level      (m_irq_level),
        .m_notify_seen    (m_notify_seen),
        .m_notify_queue   (m_notify_queue),
        .m_config_touched (m_config_touched),
        .cmd              (dp_cmd),
        .sts              (dp_sts)
    );

endmodule

/* dv/tb_virtio_mmio_register_block_top.sv */
`timescale 1ns / 1ps
// Testbench of virtio_mmio_register_block_top: directed table, then random bus traffic
// checked beat by beat against a register and config model. Needs vmmio_pkg and the RTL.
module tb_virtio_mmio_register_block_top;
    import vmmio_pkg::*;

    localparam int NQ        = QUEUE_COUNT_DEF;
    localparam int QMAX      = QUEUE_SIZE_MAX_DEF;
    localparam int CFG_LIMIT = CONFIG_BYTES_DEF;
    localparam int PHASE_BEATS = 205;
    localparam int STUCK_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 40;

    localparam logic [11:0] REG_MAP [20] = '{
        OFF_MAGIC, OFF_VERSION, OFF_DEV_ID, OFF_VENDOR_ID, OFF_DEV_FEAT, OFF_FEAT_SEL,
        OFF_QUEUE_SEL, OFF_QUEUE_MAX, OFF_QUEUE_NUM, OFF_QUEUE_RDY, OFF_NOTIFY,
        OFF_INT_STAT, OFF_INT_ACK, OFF_STATUS, OFF_DESC_LO, OFF_DESC_HI,
        OFF_AVAIL_LO, OFF_AVAIL_HI, OFF_USED_LO, OFF_USED_HI
    };

    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] off;
        logic [31:0] wval;
        logic [1:0]  sz;
    } access_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic        irq;
        logic        nseen;
        logic [2:0]  nq;
        logic        touched;
    } reply_t;

    typedef struct packed {
        access_t acc;
        logic    typed;
        reply_t  want;
    } drow_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = CREG_DEVICE_KIND;
    logic [31:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd = CMD_READ;
    logic [11:0] s_bus_offset = '0;
    logic [31:0] s_write_value = '0;
    logic [1:0]  s_size_code = SZ_WORD;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_read_value;
    logic        m_irq_level;
    logic        m_notify_seen;
    logic [2:0]  m_notify_queue;
    logic        m_config_touched;

    logic [31:0] set_kind, set_vendor, set_feats;
    logic [8:0]  set_cfg_size;

    logic [31:0] sts_reg, fsel_reg;
    logic [2:0]  qsel_reg;
    logic [1:0]  isr_reg;
    logic        qrdy [NQ];
    logic [31:0] qnum [NQ];
    logic [63:0] qdesc [NQ];
    logic [63:0] qavail [NQ];
    logic [63:0] qused [NQ];
    logic [7:0]  cfg_space [CFG_LIMIT];

    reply_t pending_replies[$];
    drow_t  directed_rows[$];
    int     fault_count = 0;
    int     stuck_cycles = 0;
    int     stall_left = 0;
    bit     calm = 1'b0;

    virtio_mmio_register_block_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_bus_offset     (s_bus_offset),
        .s_write_value    (s_write_value),
        .s_size_code      (s_size_code),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_read_value     (m_read_value),
        .m_irq_level      (m_irq_level),
        .m_notify_seen    (m_notify_seen),
        .m_notify_queue   (m_notify_queue),
        .m_config_touched (m_config_touched)
    );

    always #10 aclk = ~aclk;

    function automatic void clear_transport();
        sts_reg  = '0;
        fsel_reg = '0;
        qsel_reg = '0;
        isr_reg  = '0;
        for (int i = 0; i < NQ; i++) begin
            qrdy[i]   = 1'b0;
            qnum[i]   = QMAX;
            qdesc[i]  = '0;
            qavail[i] = '0;
            qused[i]  = '0;
        end
    endfunction

    function automatic reply_t mmio_step(input access_t a);
        reply_t      r;
        logic [2:0]  q;
        int unsigned base, nbytes, bound;
        r = '0;
        q = qsel_reg;
        nbytes = 1 << a.sz;
        bound = (set_cfg_size > CFG_LIMIT) ? CFG_LIMIT : set_cfg_size;
        base = a.off - CFG_BASE;
        case (a.cmd)
            CMD_READ: begin
                if (a.off >= CFG_BASE) begin
                    if (a.sz != SZ_RSVD && base + nbytes <= bound)
                        for (int k = 0; k < nbytes; k++)
                            r.rdata[8*k +: 8] = cfg_space[base + k];
                end else if (a.sz == SZ_WORD) begin
                    case (a.off)
                        OFF_MAGIC:     r.rdata = MAGIC_WORD;
                        OFF_VERSION:   r.rdata = VERSION_WORD;
                        OFF_DEV_ID:    r.rdata = set_kind;
                        OFF_VENDOR_ID: r.rdata = set_vendor;
                        OFF_DEV_FEAT: begin
                            if (fsel_reg == 0)
                                r.rdata = set_feats;
                            else if (fsel_reg == 1)
                                r.rdata = 32'd1;
                        end
                        OFF_FEAT_SEL:  r.rdata = fsel_reg;
                        OFF_QUEUE_SEL: r.rdata = qsel_reg;
                        OFF_QUEUE_MAX: r.rdata = QMAX;
                        OFF_QUEUE_NUM: r.rdata = qnum[q];
                        OFF_QUEUE_RDY: r.rdata = qrdy[q];
                        OFF_INT_STAT:  r.rdata = isr_reg;
                        OFF_STATUS:    r.rdata = sts_reg;
                        OFF_DESC_LO:   r.rdata = qdesc[q][31:0];
                        OFF_DESC_HI:   r.rdata = qdesc[q][63:32];
                        OFF_AVAIL_LO:  r.rdata = qavail[q][31:0];
                        OFF_AVAIL_HI:  r.rdata = qavail[q][63:32];
                        OFF_USED_LO:   r.rdata = qused[q][31:0];
                        OFF_USED_HI:   r.rdata = qused[q][63:32];
                        default:       r.rdata = '0;
                    endcase
                end
            end
            CMD_WRITE: begin
                if (a.off >= CFG_BASE) begin
                    if (a.sz != SZ_RSVD && base + nbytes <= bound) begin
                        for (int k = 0; k < nbytes; k++)
                            cfg_space[base + k] = a.wval[8*k +: 8];
                        r.touched = 1'b1;
                    end
                end else if (a.sz == SZ_WORD) begin
                    case (a.off)
                        OFF_FEAT_SEL: fsel_reg = a.wval;
                        OFF_QUEUE_SEL: begin
                            if (a.wval < NQ)
                                qsel_reg = a.wval[2:0];
                        end
                        OFF_QUEUE_NUM: begin
                            if (a.wval != 0 && (a.wval & (a.wval - 1)) == 0)
                                qnum[q] = a.wval;
                        end
                        OFF_QUEUE_RDY: qrdy[q] = a.wval[0];
                        OFF_NOTIFY: begin
                            if (a.wval < NQ) begin
                                r.nseen = 1'b1;
                                r.nq    = a.wval[2:0];
                            end
                        end
                        OFF_INT_ACK: isr_reg = isr_reg & ~a.wval[1:0];
                        OFF_STATUS: begin
                            sts_reg = a.wval;
                            if (a.wval == 0)
                                clear_transport();
                        end
                        OFF_DESC_LO:  qdesc[q][31:0]   = a.wval;
                        OFF_DESC_HI:  qdesc[q][63:32]  = a.wval;
                        OFF_AVAIL_LO: qavail[q][31:0]  = a.wval;
                        OFF_AVAIL_HI: qavail[q][63:32] = a.wval;
                        OFF_USED_LO:  qused[q][31:0]   = a.wval;
                        OFF_USED_HI:  qused[q][63:32]  = a.wval;
                        default: ;
                    endcase
                end
            end
            CMD_USED_EVT: isr_reg = isr_reg | 2'b01;
            default:      isr_reg = isr_reg | 2'b10;
        endcase
        r.irq = (isr_reg != 0);
        return r;
    endfunction

    function automatic access_t pick_access();
        access_t     a;
        int unsigned roll, bound, szroll;
        roll = $urandom_range(0, 99);
        a.cmd  = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
        a.wval = $urandom;
        a.sz   = SZ_WORD;
        a.off  = OFF_MAGIC;
        if (roll < 10) begin
            a.cmd = $urandom_range(0, 1) ? CMD_USED_EVT : CMD_CFG_EVT;
            a.off = $urandom_range(0, 4095);
        end else if (roll < 55) begin
            a.off = REG_MAP[$urandom_range(0, 19)];
            case (a.off)
                OFF_FEAT_SEL:  if ($urandom_range(0, 3) != 0) a.wval = $urandom_range(0, 3);
                OFF_QUEUE_SEL: if ($urandom_range(0, 4) != 0) a.wval = $urandom_range(0, NQ - 1);
                OFF_QUEUE_NUM: if ($urandom_range(0, 3) != 0) a.wval = 32'd1 << $urandom_range(0, 31);
                OFF_QUEUE_RDY: if ($urandom_range(0, 1) != 0) a.wval = $urandom_range(0, 1);
                OFF_NOTIFY:    if ($urandom_range(0, 3) != 0) a.wval = $urandom_range(0, NQ - 1);
                OFF_INT_ACK:   if ($urandom_range(0, 3) != 0) a.wval = $urandom_range(0, 3);
                OFF_STATUS:    if ($urandom_range(0, 2) == 0) a.wval = '0;
                default: ;
            endcase
        end else if (roll < 82) begin
            bound = (set_cfg_size > CFG_LIMIT) ? CFG_LIMIT : set_cfg_size;
            a.off = CFG_BASE + $urandom_range(0, bound + 3);
            szroll = $urandom_range(0, 15);
            a.sz = (szroll < 5) ? SZ_BYTE : (szroll < 10) ? SZ_HALF :
                   (szroll < 15) ? SZ_WORD : SZ_RSVD;
        end else if (roll < 90) begin
            a.off = $urandom_range(0, 63) * 4;
            a.sz  = $urandom_range(0, 3);
        end else begin
            a.cmd = $urandom_range(0, 3);
            a.off = $urandom_range(0, 4095);
            a.sz  = $urandom_range(0, 3);
        end
        return a;
    endfunction

    function automatic void row_fixed(input logic [1:0] cmd, input logic [11:0] off,
                                      input logic [31:0] wval, input logic [1:0] sz,
                                      input logic [31:0] rd, input logic irq,
                                      input logic ns, input logic [2:0] nq,
                                      input logic tch);
        directed_rows.push_back('{'{cmd, off, wval, sz}, 1'b1, '{rd, irq, ns, nq, tch}});
    endfunction

    function automatic void row_model(input logic [1:0] cmd, input logic [11:0] off,
                                      input logic [31:0] wval, input logic [1:0] sz);
        directed_rows.push_back('{'{cmd, off, wval, sz}, 1'b0, reply_t'('0)});
    endfunction

    task automatic send_access(input access_t a, input logic typed, input reply_t want);
        reply_t modeled;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= a.cmd;
        s_bus_offset  <= a.off;
        s_write_value <= a.wval;
        s_size_code   <= a.sz;
        do @(posedge aclk); while (!s_ready);
        modeled = mmio_step(a);
        pending_replies.push_back(typed ? want : modeled);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge aclk);
    endtask

    task automatic load_settings(input logic [31:0] kind, input logic [31:0] vend,
                                 input logic [31:0] feats, input logic [8:0] csize);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CREG_DEVICE_KIND;
        cfg_wr_data <= kind;
        @(posedge aclk);
        cfg_index   <= CREG_VENDOR_CODE;
        cfg_wr_data <= vend;
        @(posedge aclk);
        cfg_index   <= CREG_FEATURE_BITS;
        cfg_wr_data <= feats;
        @(posedge aclk);
        cfg_index   <= CREG_CONFIG_SIZE;
        cfg_wr_data <= {23'd0, csize};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        set_kind     = kind;
        set_vendor   = vend;
        set_feats    = feats;
        set_cfg_size = csize;
    endtask

    task automatic run_random(input int beats);
        for (int i = 0; i < beats; i++)
            send_access(pick_access(), 1'b0, reply_t'('0));
        drain();
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 12);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                if (fault_count < 10)
                    $display("unexpected result beat: rd=%h irq=%b", m_read_value, m_irq_level);
                fault_count++;
            end else begin
                want = pending_replies.pop_front();
                if (m_read_value !== want.rdata || m_irq_level !== want.irq ||
                    m_notify_seen !== want.nseen || m_notify_queue !== want.nq ||
                    m_config_touched !== want.touched) begin
                    if (fault_count < 10)
                        $display("mismatch: exp rd=%h irq=%b ns=%b nq=%0d ct=%b got rd=%h irq=%b ns=%b nq=%0d ct=%b",
                                 want.rdata, want.irq, want.nseen, want.nq, want.touched,
                                 m_read_value, m_irq_level, m_notify_seen, m_notify_queue,
                                 m_config_touched);
                    fault_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("tb_virtio_mmio_register_block_top: done, errors");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        set_kind     = DEVICE_KIND_RST;
        set_vendor   = VENDOR_CODE_RST;
        set_feats    = FEATURE_BITS_RST;
        set_cfg_size = CONFIG_SIZE_RST;
        clear_transport();
        for (int i = 0; i < CFG_LIMIT; i++)
            cfg_space[i] = '0;

        row_fixed(CMD_READ,  OFF_MAGIC,     '0, SZ_WORD, MAGIC_WORD, 0, 0, 0, 0);
        row_fixed(CMD_READ,  OFF_DEV_ID,    '0, SZ_WORD, DEVICE_KIND_RST, 0, 0, 0, 0);
        row_fixed(CMD_READ,  OFF_VENDOR_ID, '0, SZ_WORD, VENDOR_CODE_RST, 0, 0, 0, 0);
        row_fixed(CMD_READ,  OFF_DEV_FEAT,  '0, SZ_WORD, FEATURE_BITS_RST, 0, 0, 0, 0);
        row_fixed(CMD_READ,  OFF_QUEUE_MAX, '0, SZ_WORD, QMAX, 0, 0, 0, 0);
        row_fixed(CMD_READ,  OFF_QUEUE_NUM, '0, SZ_WORD, QMAX, 0, 0, 0, 0);
        row_fixed(CMD_READ,  OFF_MAGIC,     '0, SZ_BYTE, '0, 0, 0, 0, 0);
        row_fixed(CMD_WRITE, OFF_FEAT_SEL,  32'd1, SZ_WORD, '0, 0, 0, 0, 0);
        row_fixed(CMD_READ,  OFF_DEV_FEAT,  '0, SZ_WORD, 32'd1, 0, 0, 0, 0);
        row_model(CMD_WRITE, OFF_QUEUE_SEL, 32'd8, SZ_WORD);
        row_model(CMD_WRITE, OFF_QUEUE_SEL, 32'd7, SZ_WORD);
        row_model(CMD_WRITE, OFF_QUEUE_NUM, 32'd12, SZ_WORD);
        row_model(CMD_WRITE, OFF_QUEUE_NUM, 32'h8000_0000, SZ_WORD);
        row_model(CMD_READ,  OFF_QUEUE_NUM, '0, SZ_WORD);
        row_model(CMD_WRITE, OFF_DESC_HI,   32'hffff_ffff, SZ_WORD);
        row_model(CMD_READ,  OFF_DESC_HI,   '0, SZ_WORD);
        row_fixed(CMD_WRITE, OFF_NOTIFY,    32'd7, SZ_WORD, '0, 0, 1, 3'd7, 0);
        row_fixed(CMD_WRITE, OFF_NOTIFY,    32'hffff_ffff, SZ_WORD, '0, 0, 0, 0, 0);
        row_fixed(CMD_USED_EVT, OFF_MAGIC,  '0, SZ_WORD, '0, 1, 0, 0, 0);
        row_fixed(CMD_CFG_EVT,  OFF_MAGIC,  '0, SZ_WORD, '0, 1, 0, 0, 0);
        row_fixed(CMD_READ,  OFF_INT_STAT,  '0, SZ_WORD, 32'd3, 1, 0, 0, 0);
        row_model(CMD_WRITE, OFF_INT_ACK,   32'd1, SZ_WORD);
        row_fixed(CMD_WRITE, CFG_BASE + 12'h004, 32'hffff_ffff, SZ_WORD, '0, 1, 0, 0, 1);
        row_model(CMD_READ,  CFG_BASE + 12'h005, '0, SZ_HALF);
        row_fixed(CMD_WRITE, CFG_BASE + 12'h005, 32'h1234_5678, SZ_WORD, '0, 1, 0, 0, 0);
        row_fixed(CMD_READ,  CFG_BASE, '0, SZ_RSVD, '0, 1, 0, 0, 0);
        row_fixed(CMD_WRITE, OFF_STATUS,    '0, SZ_WORD, '0, 0, 0, 0, 0);
        row_fixed(CMD_READ,  OFF_QUEUE_NUM, '0, SZ_WORD, QMAX, 0, 0, 0, 0);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_access(directed_rows[i].acc, directed_rows[i].typed, directed_rows[i].want);
        drain();

        load_settings('0, '0, '0, 9'd4);
        run_random(PHASE_BEATS);
        load_settings(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 9'd256);
        run_random(PHASE_BEATS);
        load_settings($urandom, $urandom, $urandom, 4 * $urandom_range(2, 63));
        run_random(PHASE_BEATS);
        load_settings($urandom, $urandom, $urandom, 9'd128);
        run_random(PHASE_BEATS);
        load_settings($urandom, $urandom, $urandom, 9'd64);
        calm = 1'b1;
        run_random(PHASE_BEATS);

        repeat (SETTLE_CYCLES) @(posedge aclk);
        fault_count += pending_replies.size();
        if (fault_count == 0)
            $display("tb_virtio_mmio_register_block_top: done, clean");
        else
            $display("tb_virtio_mmio_register_block_top: done, errors");
        $finish;
    end
endmodule
